// ----- rtl/core/abbt_pkg.sv -----
// Package for the affine box bounds transform: types, register indexes and helpers.
`default_nettype none

package abbt_pkg;

  localparam int unsigned QW      = 32;  // Q16.16 word
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned PROD_W  = 2 * QW;
  localparam int unsigned TERM_W  = PROD_W - FRAC_W;  // product after the shift
  localparam int unsigned PSUM_W  = TERM_W + 1;        // sum of two terms
  localparam int unsigned TOTAL_W = TERM_W + 2;        // sum of four terms
  localparam int unsigned REG_W   = 64;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned NAXES   = 3;

  typedef logic signed [QW-1:0]      q_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [PSUM_W-1:0]  psum_t;
  typedef logic signed [TOTAL_W-1:0] total_t;

  typedef logic [IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_MAT_A    = 3'd0;
  localparam reg_idx_t REG_MAT_B    = 3'd1;
  localparam reg_idx_t REG_MAT_C    = 3'd2;
  localparam reg_idx_t REG_MAT_D    = 3'd3;
  localparam reg_idx_t REG_MAT_E_TX = 3'd4;
  localparam reg_idx_t REG_TRANS_YZ = 3'd5;

  // identity diagonal entry in the low half, zero elsewhere
  localparam logic [REG_W-1:0] RST_DIAG = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] RST_ZERO = 64'h0;

  localparam total_t SAT_MAX = TOTAL_W'(64'sd2147483647);
  localparam total_t SAT_MIN = TOTAL_W'(-64'sd2147483648);

  function automatic q_t sat_q(input total_t v);
    q_t r;
    if (v > SAT_MAX) begin
      r = q_t'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r = q_t'(SAT_MIN);
    end else begin
      r = v[QW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/affine_box_bounds_transform_core.sv -----
// Affine transform of an axis-aligned box to its new axis-aligned bounds, four-stage pipeline.
`default_nettype none

// Channel   Direction  Handshake                  Payload
// --------  ---------  -------------------------  ------------------------------------------
// input     in         in_valid_i / in_stall_o    lo_x/y/z_i, hi_x/y/z_i, is_last_i
// output    out        out_valid_o / out_stall_i  out_lo_x/y/z_o, out_hi_x/y/z_o, out_last_o
// config    in         cfg_we_i (no handshake)    cfg_idx_i, cfg_data_i
//
// One box per cycle sustained while out_stall_i is low; each box passes stages 1 to 4 in order.
// Stages: 18 parallel 32x32 multiplies | min/max per term | pairwise adds | final add+saturate.
// Each stage holds its item while the next is full and stalled; a bubble lets it advance,
// so a stall at the output backs up one stage at a time and nothing is dropped.
// Reset (rst_ni low, async) empties the pipeline and loads the identity matrix, zero offset.
// Config registers are read live by stages 1 and 3; write them only while the block is idle.
module affine_box_bounds_transform_core
  import abbt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               cfg_we_i,
  input  wire logic [IDX_W-1:0]   cfg_idx_i,
  input  wire logic [REG_W-1:0]   cfg_data_i,

  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] lo_x_i,
  input  wire logic signed [31:0] lo_y_i,
  input  wire logic signed [31:0] lo_z_i,
  input  wire logic signed [31:0] hi_x_i,
  input  wire logic signed [31:0] hi_y_i,
  input  wire logic signed [31:0] hi_z_i,
  input  wire logic               is_last_i,

  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      out_lo_x_o,
  output logic signed [31:0]      out_lo_y_o,
  output logic signed [31:0]      out_lo_z_o,
  output logic signed [31:0]      out_hi_x_o,
  output logic signed [31:0]      out_hi_y_o,
  output logic signed [31:0]      out_hi_z_o,
  output logic                    out_last_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [REG_W-1:0] mat_a_q, mat_b_q, mat_c_q, mat_d_q, mat_e_tx_q, trans_yz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_a_q    <= RST_DIAG;
      mat_b_q    <= RST_ZERO;
      mat_c_q    <= RST_DIAG;
      mat_d_q    <= RST_ZERO;
      mat_e_tx_q <= RST_DIAG;
      trans_yz_q <= RST_ZERO;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAT_A:    mat_a_q    <= cfg_data_i;
        REG_MAT_B:    mat_b_q    <= cfg_data_i;
        REG_MAT_C:    mat_c_q    <= cfg_data_i;
        REG_MAT_D:    mat_d_q    <= cfg_data_i;
        REG_MAT_E_TX: mat_e_tx_q <= cfg_data_i;
        REG_TRANS_YZ: trans_yz_q <= cfg_data_i;
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // Unpack matrix m[row][col] (row vector times matrix) and translation t[col].
  q_t m [NAXES][NAXES];
  q_t t [NAXES];

  always_comb begin
    m[0][0] = mat_a_q[31:0];     m[0][1] = mat_a_q[63:32];
    m[0][2] = mat_b_q[31:0];     m[1][0] = mat_b_q[63:32];
    m[1][1] = mat_c_q[31:0];     m[1][2] = mat_c_q[63:32];
    m[2][0] = mat_d_q[31:0];     m[2][1] = mat_d_q[63:32];
    m[2][2] = mat_e_tx_q[31:0];
    t[0]    = mat_e_tx_q[63:32];
    t[1]    = trans_yz_q[31:0];
    t[2]    = trans_yz_q[63:32];
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its item moves on.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o  = !en1;
  assign out_valid_o = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: products lo[r]*m[r][c] and hi[r]*m[r][c], floored by 2^16.
  // Arrays are indexed [col][row].
  // ---------------------------------------------------------------------------
  q_t    src_lo [NAXES];
  q_t    src_hi [NAXES];
  term_t p_lo_d [NAXES][NAXES];
  term_t p_hi_d [NAXES][NAXES];
  term_t p_lo_q [NAXES][NAXES];
  term_t p_hi_q [NAXES][NAXES];
  logic  last1_q;

  assign src_lo[0] = lo_x_i;
  assign src_lo[1] = lo_y_i;
  assign src_lo[2] = lo_z_i;
  assign src_hi[0] = hi_x_i;
  assign src_hi[1] = hi_y_i;
  assign src_hi[2] = hi_z_i;

  always_comb begin
    prod_t pl;
    prod_t ph;
    for (int c = 0; c < NAXES; c++) begin
      for (int r = 0; r < NAXES; r++) begin
        pl = PROD_W'(src_lo[r]) * PROD_W'(m[r][c]);
        ph = PROD_W'(src_hi[r]) * PROD_W'(m[r][c]);
        // arithmetic shift right: floor toward minus infinity
        p_lo_d[c][r] = pl[PROD_W-1:FRAC_W];
        p_hi_d[c][r] = ph[PROD_W-1:FRAC_W];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      p_lo_q  <= p_lo_d;
      p_hi_q  <= p_hi_d;
      last1_q <= is_last_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: per term, the smaller value goes to the min sum, the larger to max.
  // ---------------------------------------------------------------------------
  term_t mn_d [NAXES][NAXES];
  term_t mx_d [NAXES][NAXES];
  term_t mn_q [NAXES][NAXES];
  term_t mx_q [NAXES][NAXES];
  logic  last2_q;

  always_comb begin
    for (int c = 0; c < NAXES; c++) begin
      for (int r = 0; r < NAXES; r++) begin
        if (p_lo_q[c][r] < p_hi_q[c][r]) begin
          mn_d[c][r] = p_lo_q[c][r];
          mx_d[c][r] = p_hi_q[c][r];
        end else begin
          mn_d[c][r] = p_hi_q[c][r];
          mx_d[c][r] = p_lo_q[c][r];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      mn_q    <= mn_d;
      mx_q    <= mx_d;
      last2_q <= last1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: pairwise sums; translation joins the third term.
  // ---------------------------------------------------------------------------
  psum_t mn01_d [NAXES];
  psum_t mn2t_d [NAXES];
  psum_t mx01_d [NAXES];
  psum_t mx2t_d [NAXES];
  psum_t mn01_q [NAXES];
  psum_t mn2t_q [NAXES];
  psum_t mx01_q [NAXES];
  psum_t mx2t_q [NAXES];
  logic  last3_q;

  always_comb begin
    for (int c = 0; c < NAXES; c++) begin
      mn01_d[c] = PSUM_W'(mn_q[c][0]) + PSUM_W'(mn_q[c][1]);
      mn2t_d[c] = PSUM_W'(mn_q[c][2]) + PSUM_W'(t[c]);
      mx01_d[c] = PSUM_W'(mx_q[c][0]) + PSUM_W'(mx_q[c][1]);
      mx2t_d[c] = PSUM_W'(mx_q[c][2]) + PSUM_W'(t[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      mn01_q  <= mn01_d;
      mn2t_q  <= mn2t_d;
      mx01_q  <= mx01_d;
      mx2t_q  <= mx2t_d;
      last3_q <= last2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: final add, saturate to 32 bits, output register.
  // ---------------------------------------------------------------------------
  q_t   olo_d [NAXES];
  q_t   ohi_d [NAXES];
  q_t   olo_q [NAXES];
  q_t   ohi_q [NAXES];
  logic last4_q;

  always_comb begin
    for (int c = 0; c < NAXES; c++) begin
      olo_d[c] = sat_q(TOTAL_W'(mn01_q[c]) + TOTAL_W'(mn2t_q[c]));
      ohi_d[c] = sat_q(TOTAL_W'(mx01_q[c]) + TOTAL_W'(mx2t_q[c]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      olo_q   <= olo_d;
      ohi_q   <= ohi_d;
      last4_q <= last3_q;
    end
  end

  assign out_lo_x_o = olo_q[0];
  assign out_lo_y_o = olo_q[1];
  assign out_lo_z_o = olo_q[2];
  assign out_hi_x_o = ohi_q[0];
  assign out_hi_y_o = ohi_q[1];
  assign out_hi_z_o = ohi_q[2];
  assign out_last_o = last4_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // Bounds never invert: min <= max on every axis.
  a_bounds_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_lo_x_o <= out_hi_x_o) && (out_lo_y_o <= out_hi_y_o) &&
                    (out_lo_z_o <= out_hi_z_o))
    else $error("output bounds inverted");

  // Upstream is stalled only when every stage is full and the output is stalled.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && out_stall_i))
    else $error("input stalled with a free pipeline slot");

  // A held stage-3 item keeps its partial sums.
  a_stage3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !en3) |=> (v3_q && $stable(mn01_q[0]) && $stable(mx2t_q[2]) &&
                        $stable(last3_q)))
    else $error("stage 3 item lost while held");

  // A stalled output item does not vanish before it is taken.
  a_out_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("output item dropped under stall");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Testbench for the affine box bounds core: directed and random boxes checked against a predictor.
`default_nettype none

module tb_top;
  import abbt_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 11;
  localparam int PIPE_DEPTH   = 4;
  localparam int NUM_CFG_REGS = 6;
  localparam int TRANS_HALF   = 9;  // halves 9..11 hold the translation
  localparam int MAX_GAP      = 7;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_ITEMS  = 220;
  localparam int FLOOD_ITEMS  = 40;
  localparam int HOLD_LEN     = 80;
  localparam longint TIMEOUT_CYCLES = 400000;

  // indexes past the register file; writes there must leave the matrix alone
  localparam reg_idx_t REG_SPARE_6 = 3'd6;
  localparam reg_idx_t REG_SPARE_7 = 3'd7;

  localparam q_t Q_MAX     = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN     = 32'sh8000_0000;
  localparam q_t Q_ONE     = 32'sh0001_0000;
  localparam q_t Q_NEG_ONE = 32'shFFFF_0000;
  localparam q_t Q_LSB_NEG = 32'shFFFF_FFFF;

  typedef struct packed {
    q_t   lo_x;
    q_t   lo_y;
    q_t   lo_z;
    q_t   hi_x;
    q_t   hi_y;
    q_t   hi_z;
    logic last;
  } box_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  reg_idx_t         cfg_idx_i;
  logic [REG_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  q_t               lo_x_i, lo_y_i, lo_z_i, hi_x_i, hi_y_i, hi_z_i;
  logic             is_last_i;
  logic             out_valid_o;
  logic             out_stall_i;
  q_t               out_lo_x_o, out_lo_y_o, out_lo_z_o, out_hi_x_o, out_hi_y_o, out_hi_z_o;
  logic             out_last_o;

  logic [REG_W-1:0] cfg_shadow [NUM_CFG_REGS];
  box_t             bounds_due [$];
  int unsigned      mismatches;
  bit               in_pace_on;
  bit               out_pace_on;
  int unsigned      hold_cycles;

  affine_box_bounds_transform_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .lo_x_i      (lo_x_i),
    .lo_y_i      (lo_y_i),
    .lo_z_i      (lo_z_i),
    .hi_x_i      (hi_x_i),
    .hi_y_i      (hi_y_i),
    .hi_z_i      (hi_z_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_lo_x_o  (out_lo_x_o),
    .out_lo_y_o  (out_lo_y_o),
    .out_lo_z_o  (out_lo_z_o),
    .out_hi_x_o  (out_hi_x_o),
    .out_hi_y_o  (out_hi_y_o),
    .out_hi_z_o  (out_hi_z_o),
    .out_last_o  (out_last_o)
  );

  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  // Half k of the register file, sign-extended: 0..8 are m[r][c] row-major.
  function automatic longint coef_half(input int k);
    logic [REG_W-1:0] word;
    logic [QW-1:0]    half;
    longint           v;
    word = cfg_shadow[k / 2];
    half = (k % 2 == 1) ? word[REG_W-1:QW] : word[QW-1:0];
    v = $signed(half);
    return v;
  endfunction

  function automatic q_t clamp_q(input longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return q_t'(v);
  endfunction

  // Per axis, the bounds are the translation plus the smaller / larger of each
  // row's two floored products; corners never need to be enumerated.
  function automatic box_t transform_bounds(input box_t b);
    longint src_lo [NAXES];
    longint src_hi [NAXES];
    q_t     dst_lo [NAXES];
    q_t     dst_hi [NAXES];
    longint coef, p_lo, p_hi, acc_lo, acc_hi;
    box_t   r;
    src_lo[0] = $signed(b.lo_x);
    src_lo[1] = $signed(b.lo_y);
    src_lo[2] = $signed(b.lo_z);
    src_hi[0] = $signed(b.hi_x);
    src_hi[1] = $signed(b.hi_y);
    src_hi[2] = $signed(b.hi_z);
    for (int c = 0; c < NAXES; c++) begin
      acc_lo = coef_half(TRANS_HALF + c);
      acc_hi = acc_lo;
      for (int k = 0; k < NAXES; k++) begin
        coef = coef_half(k * NAXES + c);
        // arithmetic shift floors toward minus infinity
        p_lo = (src_lo[k] * coef) >>> FRAC_W;
        p_hi = (src_hi[k] * coef) >>> FRAC_W;
        if (p_lo < p_hi) begin
          acc_lo += p_lo;
          acc_hi += p_hi;
        end else begin
          acc_lo += p_hi;
          acc_hi += p_lo;
        end
      end
      dst_lo[c] = clamp_q(acc_lo);
      dst_hi[c] = clamp_q(acc_hi);
    end
    r.lo_x = dst_lo[0];
    r.lo_y = dst_lo[1];
    r.lo_z = dst_lo[2];
    r.hi_x = dst_hi[0];
    r.hi_y = dst_hi[1];
    r.hi_z = dst_hi[2];
    r.last = b.last;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic box_t make_box(input q_t lx, ly, lz, hx, hy, hz, input logic last);
    box_t b;
    b.lo_x = lx;
    b.lo_y = ly;
    b.lo_z = lz;
    b.hi_x = hx;
    b.hi_y = hy;
    b.hi_z = hz;
    b.last = last;
    return b;
  endfunction

  // Tame values mostly stay within +-256.0 (one in sixteen is fully random) so most sums land inside range.
  function automatic q_t pick_q(input bit tame);
    if (tame) begin
      if ($urandom_range(0, 15) == 0) return q_t'($urandom());
      return q_t'($urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
    end
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return '0;
      3:       return q_t'($urandom_range(0, 32'h0200_0000) - 32'h0100_0000);
      default: return q_t'($urandom());
    endcase
  endfunction

  // Tame coefficients stay within +-4.0, with exact zero and unit now and then.
  function automatic q_t pick_coef(input bit tame);
    if (!tame) return pick_q(1'b0);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return Q_ONE;
      2:       return Q_NEG_ONE;
      default: return q_t'($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
    endcase
  endfunction

  function automatic box_t random_box(input bit tame);
    return make_box(pick_q(tame), pick_q(tame), pick_q(tame),
                    pick_q(tame), pick_q(tame), pick_q(tame), 1'($urandom()));
  endfunction

  // Called at a rising edge; returns at one.
  task automatic write_reg(input reg_idx_t idx, input logic [REG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx < NUM_CFG_REGS) cfg_shadow[idx] = data;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_all(input q_t m00, m01, m02, m10, m11, m12, m20, m21, m22,
                          input q_t tx, ty, tz);
    write_reg(REG_MAT_A,    {m01, m00});
    write_reg(REG_MAT_B,    {m10, m02});
    write_reg(REG_MAT_C,    {m12, m11});
    write_reg(REG_MAT_D,    {m21, m20});
    write_reg(REG_MAT_E_TX, {tx, m22});
    write_reg(REG_TRANS_YZ, {tz, ty});
  endtask

  task automatic load_random(input bit tame);
    load_all(pick_coef(tame), pick_coef(tame), pick_coef(tame),
             pick_coef(tame), pick_coef(tame), pick_coef(tame),
             pick_coef(tame), pick_coef(tame), pick_coef(tame),
             pick_q(tame), pick_q(tame), pick_q(tame));
  endtask

  // One input transfer. Valid stays high across back-to-back boxes; it only
  // drops when a gap is drawn, so each edge sees a single update of it.
  task automatic send_box(input box_t b);
    int unsigned gap;
    gap = in_pace_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    lo_x_i     <= b.lo_x;
    lo_y_i     <= b.lo_y;
    lo_z_i     <= b.lo_z;
    hi_x_i     <= b.hi_x;
    hi_y_i     <= b.hi_y;
    hi_z_i     <= b.hi_z;
    is_last_i  <= b.last;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    bounds_due.push_back(transform_bounds(b));
  endtask

  // Wait until every expected result is out and the pipe has emptied.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (bounds_due.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- tests

  // Reset values are the identity: every box comes back unchanged, but an inverted box has lo and hi swapped.
  task automatic test_identity_after_reset();
    in_pace_on  = 1'b1;
    out_pace_on = 1'b1;
    send_box(make_box('0, '0, '0, '0, '0, '0, 1'b0));
    send_box(make_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
    send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    // inverted box: min above max on every axis
    send_box(make_box(Q_MAX, Q_ONE, '0, Q_MIN, Q_NEG_ONE, Q_LSB_NEG, 1'b0));
    send_box(make_box(32'shFFFE_8000, 32'sh0002_4000, 32'sh0000_0001,
                      32'sh0003_0000, 32'shFFFF_C000, 32'sh7FFF_0000, 1'b1));
    drain();
  endtask

  task automatic test_extreme_matrix();
    box_t span;
    span = make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0);
    // largest coefficients and offsets: sums saturate both ways
    load_all(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
             Q_MAX, Q_MAX, Q_MAX);
    send_box(make_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1));
    send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
    send_box(span);
    drain();
    // most negative everywhere: min times min is the largest product
    load_all(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
             Q_MIN, Q_MIN, Q_MIN);
    send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1));
    send_box(make_box(Q_MAX, '0, Q_MIN, Q_MAX, '0, Q_MIN, 1'b0));
    send_box(span);
    drain();
    // one negative LSB per entry: tiny products must floor, not truncate to zero
    load_all(Q_LSB_NEG, Q_LSB_NEG, Q_LSB_NEG, Q_LSB_NEG, Q_LSB_NEG, Q_LSB_NEG,
             Q_LSB_NEG, Q_LSB_NEG, Q_LSB_NEG, '0, '0, '0);
    send_box(make_box(32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0000_FFFF,
                      32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0001_0000, 1'b1));
    send_box(make_box(Q_LSB_NEG, Q_ONE, Q_NEG_ONE, Q_LSB_NEG, Q_ONE, Q_NEG_ONE, 1'b0));
    drain();
    // mirrored diagonal with offsets: products swap which side they feed
    load_all(Q_NEG_ONE, '0, '0, '0, Q_NEG_ONE, '0, '0, '0, Q_NEG_ONE,
             32'sh0003_0000, Q_MAX, 32'shFFFF_8000);
    send_box(make_box(32'shFFFE_0000, 32'sh0000_0001, Q_MIN,
                      32'sh0005_8000, 32'sh0004_0000, Q_MAX, 1'b1));
    send_box(make_box(32'sh0005_8000, Q_MAX, 32'sh0001_0000,
                      32'shFFFE_0000, Q_MIN, 32'shFFFF_0000, 1'b0));
    drain();
    // writes beyond the register file are dropped
    write_reg(REG_SPARE_6, {$urandom(), $urandom()});
    write_reg(REG_SPARE_7, {$urandom(), $urandom()});
    send_box(make_box(Q_ONE, Q_NEG_ONE, '0, 32'sh0002_0000, Q_ONE, Q_MAX, 1'b1));
    send_box(span);
    drain();
  endtask

  task automatic test_random_phases();
    bit tame;
    for (int p = 0; p < NUM_PHASES; p++) begin
      tame = (p % 2 == 0) || ($urandom_range(0, 1) == 1);
      // first phase runs flat out on both sides
      in_pace_on  = (p != 0) && ($urandom_range(0, 3) != 0);
      out_pace_on = (p != 0) && ($urandom_range(0, 3) != 0);
      load_random(tame);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_box(random_box(tame));
      end
      drain();
    end
  endtask

  // Receiver holds off while the sender floods: the pipe fills and stalls input.
  task automatic test_backpressure();
    load_random(1'b1);
    in_pace_on  = 1'b0;
    out_pace_on = 1'b1;
    hold_cycles = HOLD_LEN;
    for (int n = 0; n < FLOOD_ITEMS; n++) begin
      send_box(random_box(1'b1));
    end
    drain();
  endtask

  // ---------------------------------------------------------------- output side

  // Stall draws a gap per transfer; a pending hold is applied first, ahead of that gap.
  initial begin : out_pacing
    int unsigned gap;
    int unsigned n;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      gap = out_pace_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i) && hold_cycles == 0);
    end
  end

  task automatic check_field(input string what, input logic [QW-1:0] want, got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what,
               $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk_i) begin : result_check
    box_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bounds_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result transfer, expected none, got lo_x %0d",
                 $time, out_lo_x_o);
      end else begin
        want = bounds_due.pop_front();
        check_field("out_lo_x", want.lo_x, out_lo_x_o);
        check_field("out_lo_y", want.lo_y, out_lo_y_o);
        check_field("out_lo_z", want.lo_z, out_lo_z_o);
        check_field("out_hi_x", want.hi_x, out_hi_x_o);
        check_field("out_hi_y", want.hi_y, out_hi_y_o);
        check_field("out_hi_z", want.hi_z, out_hi_z_o);
        check_field("out_last", QW'(want.last), QW'(out_last_o));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    mismatches  = 0;
    hold_cycles = 0;
    in_pace_on  = 1'b0;
    out_pace_on = 1'b0;
    cfg_shadow[REG_MAT_A]    = RST_DIAG;
    cfg_shadow[REG_MAT_B]    = RST_ZERO;
    cfg_shadow[REG_MAT_C]    = RST_DIAG;
    cfg_shadow[REG_MAT_D]    = RST_ZERO;
    cfg_shadow[REG_MAT_E_TX] = RST_DIAG;
    cfg_shadow[REG_TRANS_YZ] = RST_ZERO;
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_MAT_A;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    lo_x_i     <= '0;
    lo_y_i     <= '0;
    lo_z_i     <= '0;
    hi_x_i     <= '0;
    hi_y_i     <= '0;
    hi_z_i     <= '0;
    is_last_i  <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_identity_after_reset();
    test_extreme_matrix();
    test_random_phases();
    test_backpressure();

    if (mismatches == 0 && bounds_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
